>>> sv/dnsap_pkg.sv
package dnsap_pkg;

    // default limit on labels in one name
    localparam int DEFAULT_MAX_NAME_LABELS = 128;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_FIXED  = 3'd2,
        PH_RDATA  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // final status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_ID_MISMATCH = 4'd2;
    localparam logic [3:0] ST_NOT_RESP    = 4'd3;
    localparam logic [3:0] ST_RCODE       = 4'd4;
    localparam logic [3:0] ST_BAD_QUEST   = 4'd5;
    localparam logic [3:0] ST_BAD_ANSWER  = 4'd6;
    localparam logic [3:0] ST_BAD_RDATA   = 4'd7;
    localparam logic [3:0] ST_NO_A        = 4'd8;

    // result kinds
    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // last header byte position, header done position and last positions of the question and answer fixed fields
    localparam logic [3:0] HDR_LAST_POS  = 4'd11;
    localparam logic [3:0] HDR_DONE_POS  = 4'd12;
    localparam logic [3:0] QFIX_LAST_POS = 4'd3;
    localparam logic [3:0] AFIX_LAST_POS = 4'd9;

    // one result word
    typedef struct packed {
        logic        record_kind;
        logic [31:0] ipv4_address;
        logic [3:0]  status;
        logic [3:0]  response_code;
        logic        end_of_run;
    } result_t;

endpackage

>>> sv/dns_a_response_parser.sv
// DNS A-record response parser. Feed the response one byte per word on the s_ channel with
// s_last_byte on its final byte; the block checks the 12-byte header against cfg_wr_data
// (written with cfg_wr_en while idle), skips the questions, walks the answers and returns on
// the m_ channel one word for every class-1, type-1 answer with 4 bytes of rdata (as soon as
// its fourth rdata byte arrives) and one status word on the last byte, after which the next
// byte starts a new message. Every byte is parsed in the cycle it is accepted, so one byte a
// cycle is taken while the sink keeps up. Results go through a three-entry output queue;
// s_ready is high while the queue holds at most one word, or two while the sink takes one,
// so a last byte that also completes an address (two words) does not stall a sink that keeps
// up, and a stalled sink stops intake once two words wait.
module dns_a_response_parser #(
    parameter int MAX_NAME_LABELS = dnsap_pkg::DEFAULT_MAX_NAME_LABELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_record_kind,
    output logic [31:0] m_ipv4_address,
    output logic [3:0]  m_status,
    output logic [3:0]  m_response_code,
    output logic        m_end_of_run
);

    localparam logic [7:0] LABEL_LIMIT = 8'(MAX_NAME_LABELS);

    // error code for a message cut or broken inside a section
    function automatic logic [3:0] sec_err(input logic [15:0] q_left,
                                           input dnsap_pkg::phase_t ph);
        logic [3:0] code;
        if (q_left != 16'd0) begin
            code = dnsap_pkg::ST_BAD_QUEST;
        end else if (ph == dnsap_pkg::PH_RDATA) begin
            code = dnsap_pkg::ST_BAD_RDATA;
        end else begin
            code = dnsap_pkg::ST_BAD_ANSWER;
        end
        return code;
    endfunction

    logic [15:0] exp_id_reg;
    dnsap_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [5:0]  lbl_reg, lbl_next;
    logic [7:0]  labels_reg, labels_next;
    logic        ptr_reg, ptr_next;
    logic [3:0]  fpos_reg, fpos_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] class_reg, class_next;
    logic [15:0] rdleft_reg, rdleft_next;
    logic        isa_reg, isa_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  err_reg, err_next;
    logic [3:0]  rcode_reg, rcode_next;
    logic        found_reg, found_next;

    dnsap_pkg::result_t q_reg [3];
    dnsap_pkg::result_t q_next [3];
    logic [1:0]  count_reg, count_next;

    logic        accept;
    logic        pop;
    logic        emit_addr;
    logic        emit_stat;
    logic        do_next;
    logic [31:0] addr_res;
    logic [3:0]  st_res;
    logic [3:0]  rc_res;
    logic [15:0] word;
    logic [1:0]  push_n;
    logic [1:0]  base;
    dnsap_pkg::result_t r0, r1;

    assign s_ready = (count_reg <= 2'd1) || (count_reg == 2'd2 && m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign word    = {acc_reg[7:0], s_byte_value};

    // configured transaction id
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_id_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            exp_id_reg <= cfg_wr_data;
        end
    end

    // per-byte parse step
    always_comb begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        lbl_next    = lbl_reg;
        labels_next = labels_reg;
        ptr_next    = ptr_reg;
        fpos_next   = fpos_reg;
        type_next   = type_reg;
        class_next  = class_reg;
        rdleft_next = rdleft_reg;
        isa_next    = isa_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        rcode_next  = rcode_reg;
        found_next  = found_reg;
        emit_addr   = 1'b0;
        emit_stat   = 1'b0;
        do_next     = 1'b0;
        addr_res    = 32'd0;
        st_res      = dnsap_pkg::ST_OK;
        rc_res      = 4'd0;

        if (accept) begin
            if (phase_reg == dnsap_pkg::PH_HEADER) begin
                // header words, high byte parked in the accumulator
                case (hpos_reg)
                    4'd0, 4'd2, 4'd4, 4'd6: begin
                        acc_next = {24'd0, s_byte_value};
                    end
                    4'd1: begin
                        if (word != exp_id_reg && err_next == dnsap_pkg::ST_OK) begin
                            err_next = dnsap_pkg::ST_ID_MISMATCH;
                        end
                    end
                    4'd3: begin
                        if (!word[15] && err_next == dnsap_pkg::ST_OK) begin
                            err_next = dnsap_pkg::ST_NOT_RESP;
                        end
                        if (word[3:0] != 4'd0 && err_next == dnsap_pkg::ST_OK) begin
                            rcode_next = word[3:0];
                            err_next   = dnsap_pkg::ST_RCODE;
                        end
                    end
                    4'd5: begin
                        qleft_next = word;
                    end
                    4'd7: begin
                        aleft_next = word;
                    end
                    default: begin
                    end
                endcase
                if (hpos_reg >= dnsap_pkg::HDR_LAST_POS) begin
                    hpos_next = dnsap_pkg::HDR_DONE_POS;
                    acc_next  = 32'd0;
                    if (err_next == dnsap_pkg::ST_OK) begin
                        do_next = 1'b1;
                    end else begin
                        phase_next = dnsap_pkg::PH_DONE;
                    end
                end else begin
                    hpos_next = hpos_reg + 4'd1;
                end
            end else if (err_reg == dnsap_pkg::ST_OK) begin
                case (phase_reg)
                    dnsap_pkg::PH_NAME: begin
                        // labels, pointers and the terminating zero
                        if (ptr_reg) begin
                            ptr_next   = 1'b0;
                            phase_next = dnsap_pkg::PH_FIXED;
                            fpos_next  = 4'd0;
                        end else if (lbl_reg != 6'd0) begin
                            lbl_next = lbl_reg - 6'd1;
                        end else if (labels_reg >= LABEL_LIMIT) begin
                            err_next = sec_err(qleft_reg, phase_reg);
                        end else if (s_byte_value[7:6] == 2'b11) begin
                            ptr_next = 1'b1;
                        end else if (s_byte_value[7:6] != 2'b00) begin
                            err_next = sec_err(qleft_reg, phase_reg);
                        end else if (s_byte_value == 8'd0) begin
                            phase_next = dnsap_pkg::PH_FIXED;
                            fpos_next  = 4'd0;
                        end else begin
                            lbl_next    = s_byte_value[5:0];
                            labels_next = labels_reg + 8'd1;
                        end
                    end
                    dnsap_pkg::PH_FIXED: begin
                        if (qleft_reg != 16'd0) begin
                            // question type and class
                            if (fpos_reg >= dnsap_pkg::QFIX_LAST_POS) begin
                                qleft_next = qleft_reg - 16'd1;
                                do_next    = 1'b1;
                            end else begin
                                fpos_next = fpos_reg + 4'd1;
                            end
                        end else begin
                            // answer type, class, ttl, rdlength
                            if (fpos_reg <= 4'd1) begin
                                type_next = {type_reg[7:0], s_byte_value};
                            end else if (fpos_reg <= 4'd3) begin
                                class_next = {class_reg[7:0], s_byte_value};
                            end else if (fpos_reg >= 4'd8) begin
                                rdleft_next = {rdleft_reg[7:0], s_byte_value};
                            end
                            if (fpos_reg < dnsap_pkg::AFIX_LAST_POS) begin
                                fpos_next = fpos_reg + 4'd1;
                            end else begin
                                isa_next   = (type_reg == 16'd1) && (class_reg == 16'd1)
                                             && (rdleft_next == 16'd4);
                                type_next  = 16'd0;
                                class_next = 16'd0;
                                acc_next   = 32'd0;
                                fpos_next  = 4'd0;
                                if (rdleft_next == 16'd0) begin
                                    aleft_next = aleft_reg - 16'd1;
                                    do_next    = 1'b1;
                                end else begin
                                    phase_next = dnsap_pkg::PH_RDATA;
                                end
                            end
                        end
                    end
                    dnsap_pkg::PH_RDATA: begin
                        // rdata, collected only for an A record
                        if (isa_reg) begin
                            acc_next = {acc_reg[23:0], s_byte_value};
                        end
                        rdleft_next = rdleft_reg - 16'd1;
                        if (rdleft_next == 16'd0) begin
                            if (isa_reg) begin
                                emit_addr  = 1'b1;
                                addr_res   = acc_next;
                                found_next = 1'b1;
                            end
                            isa_next   = 1'b0;
                            acc_next   = 32'd0;
                            aleft_next = aleft_reg - 16'd1;
                            do_next    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // move on to the next record or finish
            if (do_next) begin
                if (qleft_next != 16'd0 || aleft_next != 16'd0) begin
                    phase_next  = dnsap_pkg::PH_NAME;
                    labels_next = 8'd0;
                    lbl_next    = 6'd0;
                    ptr_next    = 1'b0;
                end else begin
                    phase_next = dnsap_pkg::PH_DONE;
                end
            end

            // final status and clear for the next message
            if (s_last_byte) begin
                emit_stat = 1'b1;
                if (phase_next == dnsap_pkg::PH_HEADER) begin
                    st_res = dnsap_pkg::ST_SHORT;
                end else if (err_next != dnsap_pkg::ST_OK) begin
                    st_res = err_next;
                end else if (phase_next != dnsap_pkg::PH_DONE) begin
                    st_res = sec_err(qleft_next, phase_next);
                end else if (!found_next) begin
                    st_res = dnsap_pkg::ST_NO_A;
                end else begin
                    st_res = dnsap_pkg::ST_OK;
                end
                rc_res = (st_res == dnsap_pkg::ST_RCODE) ? rcode_next : 4'd0;

                phase_next  = dnsap_pkg::PH_HEADER;
                hpos_next   = 4'd0;
                qleft_next  = 16'd0;
                aleft_next  = 16'd0;
                lbl_next    = 6'd0;
                labels_next = 8'd0;
                ptr_next    = 1'b0;
                fpos_next   = 4'd0;
                type_next   = 16'd0;
                class_next  = 16'd0;
                rdleft_next = 16'd0;
                isa_next    = 1'b0;
                acc_next    = 32'd0;
                err_next    = dnsap_pkg::ST_OK;
                rcode_next  = 4'd0;
                found_next  = 1'b0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dnsap_pkg::PH_HEADER;
            hpos_reg   <= 4'd0;
            qleft_reg  <= 16'd0;
            aleft_reg  <= 16'd0;
            lbl_reg    <= 6'd0;
            labels_reg <= 8'd0;
            ptr_reg    <= 1'b0;
            fpos_reg   <= 4'd0;
            type_reg   <= 16'd0;
            class_reg  <= 16'd0;
            rdleft_reg <= 16'd0;
            isa_reg    <= 1'b0;
            acc_reg    <= 32'd0;
            err_reg    <= dnsap_pkg::ST_OK;
            rcode_reg  <= 4'd0;
            found_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            qleft_reg  <= qleft_next;
            aleft_reg  <= aleft_next;
            lbl_reg    <= lbl_next;
            labels_reg <= labels_next;
            ptr_reg    <= ptr_next;
            fpos_reg   <= fpos_next;
            type_reg   <= type_next;
            class_reg  <= class_next;
            rdleft_reg <= rdleft_next;
            isa_reg    <= isa_next;
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            rcode_reg  <= rcode_next;
            found_reg  <= found_next;
        end
    end

    // words produced by this byte, address first
    always_comb begin
        r1.record_kind   = dnsap_pkg::KIND_STATUS;
        r1.ipv4_address  = 32'd0;
        r1.status        = st_res;
        r1.response_code = rc_res;
        r1.end_of_run    = 1'b1;
        if (emit_addr) begin
            r0.record_kind   = dnsap_pkg::KIND_ADDRESS;
            r0.ipv4_address  = addr_res;
            r0.status        = dnsap_pkg::ST_OK;
            r0.response_code = 4'd0;
            r0.end_of_run    = !s_last_byte;
        end else begin
            r0 = r1;
        end
        push_n = 2'(emit_addr) + 2'(emit_stat);
    end

    // output queue: shift on pop, append behind the occupied entries
    always_comb begin
        base = count_reg - 2'(pop);
        for (int i = 0; i < 3; i++) begin
            if (pop && i < 2) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (push_n != 2'd0 && 2'(i) == base) begin
                q_next[i] = r0;
            end else if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
                q_next[i] = r1;
            end
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_record_kind   = q_reg[0].record_kind;
    assign m_ipv4_address  = q_reg[0].ipv4_address;
    assign m_status        = q_reg[0].status;
    assign m_response_code = q_reg[0].response_code;
    assign m_end_of_run    = q_reg[0].end_of_run;

    // a status word always closes the run of its byte
    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_kind == dnsap_pkg::KIND_STATUS |-> m_end_of_run)
        else $error("status word without end_of_run");

    // an address word carries no status or rcode
    a_addr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_kind == dnsap_pkg::KIND_ADDRESS |->
        m_status == dnsap_pkg::ST_OK && m_response_code == 4'd0)
        else $error("address word with status bits");

    // rcode only reported with the rcode status
    a_rcode_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_response_code != 4'd0 |-> m_status == dnsap_pkg::ST_RCODE)
        else $error("rcode without rcode status");

    // no address once an error is latched
    a_no_addr_after_err: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && err_reg != dnsap_pkg::ST_OK |-> !emit_addr)
        else $error("address emitted after error");

    // the last byte leaves the parser at the start of a header
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> phase_reg == dnsap_pkg::PH_HEADER && hpos_reg == 4'd0
        && err_reg == dnsap_pkg::ST_OK)
        else $error("parser not restarted after last byte");

endmodule

>>> tb/dns_a_response_parser_tb.sv
module dns_a_response_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_LABELS    = dnsap_pkg::DEFAULT_MAX_NAME_LABELS;
    localparam int RANDOM_MSGS   = 6;

    // record and header fields the parser checks
    localparam logic [15:0] TYPE_A        = 16'd1;
    localparam logic [15:0] TYPE_AAAA     = 16'd28;
    localparam logic [15:0] CLASS_IN      = 16'd1;
    localparam logic [15:0] A_RDLEN       = 16'd4;
    localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
    localparam logic [15:0] RCODE_MASK    = 16'h000f;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_record_kind;
    logic [31:0] m_ipv4_address;
    logic [3:0]  m_status;
    logic [3:0]  m_response_code;
    logic        m_end_of_run;

    dns_a_response_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_ipv4_address  (m_ipv4_address),
        .m_status        (m_status),
        .m_response_code (m_response_code),
        .m_end_of_run    (m_end_of_run)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shared test state
    dnsap_pkg::result_t expected_results[$];
    logic [7:0] msg_bytes[$];
    int         mismatch_count = 0;
    int         tx_gap_pct = IDLE_PCT;
    int         rx_stall_pct = IDLE_PCT;
    int         hold_left = 0;
    int         cycle_count = 0;

    // parser state, mirrored at the block's widths
    logic [15:0] want_id;
    logic [3:0]  hdr_pos;
    dnsap_pkg::phase_t phase;
    logic [15:0] qd_left;
    logic [15:0] an_left;
    logic [5:0]  lbl_left;
    logic [7:0]  lbl_count;
    logic        ptr_half;
    logic [3:0]  fix_pos;
    logic [15:0] rr_type;
    logic [15:0] rr_class;
    logic [15:0] rd_left;
    logic        rr_is_a;
    logic [31:0] acc;
    logic [3:0]  err_code;
    logic [3:0]  err_rcode;
    logic        any_addr;

    function automatic void clear_parser();
        hdr_pos   = '0;
        phase     = dnsap_pkg::PH_HEADER;
        qd_left   = '0;
        an_left   = '0;
        lbl_left  = '0;
        lbl_count = '0;
        ptr_half  = 1'b0;
        fix_pos   = '0;
        rr_type   = '0;
        rr_class  = '0;
        rd_left   = '0;
        rr_is_a   = 1'b0;
        acc       = '0;
        err_code  = dnsap_pkg::ST_OK;
        err_rcode = '0;
        any_addr  = 1'b0;
    endfunction

    // only the first error sticks
    function automatic void latch_err(logic [3:0] code);
        if (err_code == dnsap_pkg::ST_OK)
            err_code = code;
    endfunction

    function automatic logic [3:0] section_status();
        if (qd_left != 0)
            return dnsap_pkg::ST_BAD_QUEST;
        return (phase == dnsap_pkg::PH_RDATA) ? dnsap_pkg::ST_BAD_RDATA
                                              : dnsap_pkg::ST_BAD_ANSWER;
    endfunction

    function automatic void next_section();
        if (qd_left != 0 || an_left != 0) begin
            phase     = dnsap_pkg::PH_NAME;
            lbl_count = '0;
            lbl_left  = '0;
            ptr_half  = 1'b0;
        end else begin
            phase = dnsap_pkg::PH_DONE;
        end
    endfunction

    function automatic void expect_result(logic kind, logic [31:0] addr, logic [3:0] st,
                                          logic [3:0] rc, logic eor);
        dnsap_pkg::result_t r;
        r.record_kind   = kind;
        r.ipv4_address  = addr;
        r.status        = st;
        r.response_code = rc;
        r.end_of_run    = eor;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // header: id, flags, counts; acc holds the high byte of each word
    function automatic void header_step(logic [7:0] b);
        logic [15:0] word;
        word = {acc[7:0], b};
        case (hdr_pos)
            4'd0, 4'd2, 4'd4, 4'd6: acc = {24'd0, b};
            4'd1: if (word != want_id) latch_err(dnsap_pkg::ST_ID_MISMATCH);
            4'd3: begin
                if ((word & FLAG_RESPONSE) == 0)
                    latch_err(dnsap_pkg::ST_NOT_RESP);
                if ((word & RCODE_MASK) != 0 && err_code == dnsap_pkg::ST_OK) begin
                    err_rcode = word[3:0];
                    latch_err(dnsap_pkg::ST_RCODE);
                end
            end
            4'd5: qd_left = word;
            4'd7: an_left = word;
            default: ;
        endcase
        if (hdr_pos >= dnsap_pkg::HDR_LAST_POS) begin
            hdr_pos = dnsap_pkg::HDR_DONE_POS;
            acc     = '0;
            if (err_code == dnsap_pkg::ST_OK)
                next_section();
            else
                phase = dnsap_pkg::PH_DONE;
        end else begin
            hdr_pos++;
        end
    endfunction

    // name: labels, a zero terminator or a two-byte pointer
    function automatic void name_step(logic [7:0] b);
        if (ptr_half) begin
            ptr_half = 1'b0;
            phase    = dnsap_pkg::PH_FIXED;
            fix_pos  = '0;
        end else if (lbl_left != 0) begin
            lbl_left--;
        end else if (lbl_count >= MAX_LABELS) begin
            latch_err(section_status());
        end else if (b[7:6] == 2'b11) begin
            ptr_half = 1'b1;
        end else if (b[7:6] != 2'b00) begin
            latch_err(section_status());
        end else if (b == 8'h00) begin
            phase   = dnsap_pkg::PH_FIXED;
            fix_pos = '0;
        end else begin
            lbl_left = b[5:0];
            lbl_count++;
        end
    endfunction

    // fixed fields: 4 bytes per question, 10 per answer
    function automatic void fixed_step(logic [7:0] b);
        if (qd_left != 0) begin
            if (fix_pos >= dnsap_pkg::QFIX_LAST_POS) begin
                qd_left--;
                next_section();
            end else begin
                fix_pos++;
            end
            return;
        end
        if (fix_pos <= 1)
            rr_type = {rr_type[7:0], b};
        else if (fix_pos <= 3)
            rr_class = {rr_class[7:0], b};
        else if (fix_pos >= 8)
            rd_left = {rd_left[7:0], b};
        if (fix_pos < dnsap_pkg::AFIX_LAST_POS) begin
            fix_pos++;
            return;
        end
        rr_is_a  = (rr_type == TYPE_A && rr_class == CLASS_IN && rd_left == A_RDLEN);
        rr_type  = '0;
        rr_class = '0;
        acc      = '0;
        fix_pos  = '0;
        if (rd_left == 0) begin
            an_left--;
            next_section();
        end else begin
            phase = dnsap_pkg::PH_RDATA;
        end
    endfunction

    // one accepted byte: update state and queue the words it causes
    function automatic void parse_byte(logic [7:0] b, logic last);
        logic [3:0] st;
        logic [3:0] rc;
        if (phase == dnsap_pkg::PH_HEADER) begin
            header_step(b);
        end else if (err_code == dnsap_pkg::ST_OK) begin
            case (phase)
                dnsap_pkg::PH_NAME:  name_step(b);
                dnsap_pkg::PH_FIXED: fixed_step(b);
                dnsap_pkg::PH_RDATA: begin
                    if (rr_is_a)
                        acc = {acc[23:0], b};
                    rd_left--;
                    if (rd_left == 0) begin
                        if (rr_is_a) begin
                            expect_result(dnsap_pkg::KIND_ADDRESS, acc, dnsap_pkg::ST_OK,
                                          4'd0, !last);
                            any_addr = 1'b1;
                        end
                        rr_is_a = 1'b0;
                        acc     = '0;
                        an_left--;
                        next_section();
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            rc = 4'd0;
            if (phase == dnsap_pkg::PH_HEADER)
                st = dnsap_pkg::ST_SHORT;
            else if (err_code != dnsap_pkg::ST_OK)
                st = err_code;
            else if (phase != dnsap_pkg::PH_DONE)
                st = section_status();
            else if (!any_addr)
                st = dnsap_pkg::ST_NO_A;
            else
                st = dnsap_pkg::ST_OK;
            if (st == dnsap_pkg::ST_RCODE)
                rc = err_rcode;
            expect_result(dnsap_pkg::KIND_STATUS, 32'd0, st, rc, 1'b1);
            clear_parser();
        end
    endfunction

    // message builders
    function automatic void add_byte(logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void put16(logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endfunction

    function automatic void put_header(logic [15:0] id, logic [15:0] flags,
                                       logic [15:0] qd, logic [15:0] an);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    // zero labels means a compression pointer; zero length means random lengths
    function automatic void put_name(int labels, int len);
        int n;
        if (labels == 0) begin
            add_byte(8'hc0 | 8'($urandom_range(0, 63)));
            add_byte(8'($urandom));
        end else begin
            for (int i = 0; i < labels; i++) begin
                n = (len != 0) ? len : $urandom_range(1, 6);
                add_byte(8'(n));
                repeat (n) add_byte(8'($urandom));
            end
            add_byte(8'h00);
        end
    endfunction

    function automatic void put_question();
        put_name($urandom_range(0, 3), 0);
        repeat (4) add_byte(8'($urandom));
    endfunction

    // answer fixed fields and rdata, after its name
    function automatic void put_rr(logic [15:0] rtype, logic [15:0] rclass,
                                   logic [15:0] rdlen, logic [31:0] addr);
        put16(rtype);
        put16(rclass);
        repeat (4) add_byte(8'($urandom));
        put16(rdlen);
        for (int i = 0; i < rdlen; i++)
            add_byte(i < 4 ? addr[31 - 8 * i -: 8] : 8'($urandom));
    endfunction

    function automatic void put_answer(int labels, logic [15:0] rtype, logic [15:0] rclass,
                                       logic [15:0] rdlen, logic [31:0] addr);
        put_name(labels, 0);
        put_rr(rtype, rclass, rdlen, addr);
    endfunction

    function automatic void cut_message(int n);
        while (msg_bytes.size() > n)
            msg_bytes.delete(msg_bytes.size() - 1);
    endfunction

    // sender: one byte per word, random gaps before each word
    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_gap_pct);
        end
        s_valid      <= 1'b1;
        s_byte_value <= b;
        s_last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    // wait until every expected word has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_query_id(logic [15:0] id);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        want_id = id;
    endtask

    // receiver: random stalls, plus a long hold when asked
    initial begin : sink
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        dnsap_pkg::result_t got;
        dnsap_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_record_kind, m_ipv4_address, m_status, m_response_code, m_end_of_run};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word expected none got kind %0b addr %h status %0d",
                         $time, got.record_kind, got.ipv4_address, got.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
                check_field("ipv4_address", want.ipv4_address, got.ipv4_address);
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("response_code", 32'(want.response_code),
                            32'(got.response_code));
                check_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("dns_a_response_parser_tb: errors");
        $finish;
    end

    // A records among skipped types, trailing bytes, address on the last byte
    task automatic test_answer_records();
        put_header(want_id, 16'h8180, 16'd1, 16'd4);
        put_question();
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, 32'hffff_ffff);
        put_answer(1, TYPE_AAAA, CLASS_IN, 16'd16, $urandom);
        put_answer(0, TYPE_A, 16'd3, A_RDLEN, $urandom);
        put_answer(2, TYPE_A, CLASS_IN, A_RDLEN, 32'h0000_0000);
        repeat (3) add_byte(8'($urandom));
        send_message();
        put_header(want_id, 16'h8000, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, 32'h0a00_0001);
        send_message();
    endtask

    // id register at its extremes and a middle value
    task automatic test_query_id();
        write_query_id(16'hffff);
        put_header(16'hffff, 16'h8180, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, 32'h7f00_0001);
        send_message();
        put_header(16'hfffe, 16'h8180, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        write_query_id(16'h0000);
        put_header(16'h0000, 16'h8180, 16'd0, 16'd1);
        put_answer(1, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        put_header(16'h8000, 16'h8180, 16'd0, 16'd1);
        put_answer(1, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        write_query_id(16'h5a3c);
    endtask

    // response bit, rcode, id precedence, short messages
    task automatic test_header_checks();
        put_header(want_id, 16'h0100, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        put_header(want_id, 16'h8181, 16'd0, 16'd0);
        send_message();
        put_header(want_id, 16'h800f, 16'd0, 16'd0);
        send_message();
        // response bit clear keeps the rcode from latching
        put_header(want_id, 16'h0003, 16'd0, 16'd0);
        send_message();
        put_header(~want_id, 16'h0005, 16'd1, 16'd1);
        send_message();
        // short wins even over a header error
        add_byte(8'hff);
        send_message();
        put_header(~want_id, 16'h0000, 16'd0, 16'd0);
        cut_message(11);
        send_message();
        put_header(want_id, 16'h8000, 16'd0, 16'd0);
        send_message();
    endtask

    // reserved length bits, longest label, label limit, latched error
    task automatic test_name_rules();
        put_header(want_id, 16'h8180, 16'd1, 16'd1);
        add_byte(8'h40);
        repeat (5) add_byte(8'($urandom));
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        put_header(want_id, 16'h8180, 16'd0, 16'd2);
        put_answer(1, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        add_byte(8'h80);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        put_header(want_id, 16'h8180, 16'd1, 16'd1);
        put_name(1, 63);
        repeat (4) add_byte(8'($urandom));
        put_name(MAX_LABELS - 1, 1);
        put_rr(TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        put_header(want_id, 16'h8180, 16'd1, 16'd0);
        put_name(MAX_LABELS, 1);
        repeat (4) add_byte(8'($urandom));
        send_message();
        put_header(want_id, 16'h8180, 16'd0, 16'd1);
        put_name(MAX_LABELS, 1);
        put_rr(TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
    endtask

    // message ends inside each section
    task automatic test_truncation();
        int mark;
        put_header(want_id, 16'h8180, 16'd1, 16'd1);
        mark = msg_bytes.size();
        put_question();
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        cut_message(mark + 1);
        send_message();
        put_header(want_id, 16'h8180, 16'd1, 16'd1);
        put_question();
        mark = msg_bytes.size();
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        cut_message(mark - 1);
        send_message();
        put_header(want_id, 16'h8180, 16'd0, 16'd1);
        mark = msg_bytes.size();
        put_answer(2, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        cut_message(mark + 1);
        send_message();
        put_header(want_id, 16'h8180, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        cut_message(msg_bytes.size() - 5);
        send_message();
        put_header(want_id, 16'h8180, 16'd0, 16'd1);
        put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        cut_message(msg_bytes.size() - 2);
        send_message();
        // address on the last byte while another answer is still due
        put_header(want_id, 16'h8180, 16'd0, 16'd2);
        put_answer(1, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (3) begin
            put_header(want_id, 16'h8180, 16'd1, 16'd3);
            put_question();
            repeat (3) put_answer($urandom_range(0, 2), TYPE_A, CLASS_IN, A_RDLEN, $urandom);
            send_message();
        end
        drain();
        tx_gap_pct   = IDLE_PCT;
        rx_stall_pct = IDLE_PCT;
    endtask

    // sink holds off while the source keeps offering, so intake stalls
    task automatic test_backpressure();
        tx_gap_pct = 0;
        hold_left  = 150;
        put_header(want_id, 16'h8180, 16'd0, 16'd8);
        repeat (8) put_answer(0, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        send_message();
        drain();
        tx_gap_pct = IDLE_PCT;
    endtask

    // mostly well-formed responses, some cut, corrupted or pure noise
    task automatic test_random_traffic();
        int pick;
        int kind;
        int labels;
        int qd;
        int an;
        logic [15:0] id;
        logic [15:0] flags;
        repeat (RANDOM_MSGS) begin
            if ($urandom_range(0, 11) == 0) begin
                pick = $urandom_range(0, 3);
                write_query_id(pick == 0 ? 16'h0000 : (pick == 1 ? 16'hffff : 16'($urandom)));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
            end else begin
                id    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : want_id;
                flags = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : (16'($urandom) | FLAG_RESPONSE) & ~RCODE_MASK;
                qd = $urandom_range(0, 2);
                an = $urandom_range(0, 4);
                put_header(id, flags, 16'(qd), 16'(an));
                repeat (qd) put_question();
                repeat (an) begin
                    kind   = $urandom_range(0, 9);
                    labels = $urandom_range(0, 2);
                    if (kind < 6)
                        put_answer(labels, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
                    else if (kind == 6)
                        put_answer(labels, TYPE_AAAA, CLASS_IN, 16'd16, $urandom);
                    else if (kind == 7)
                        put_answer(labels, TYPE_A, 16'($urandom_range(0, 3)), A_RDLEN, $urandom);
                    else if (kind == 8)
                        put_answer(labels, TYPE_A, CLASS_IN, 16'($urandom_range(0, 8)), $urandom);
                    else
                        put_answer(labels, 16'($urandom), 16'($urandom),
                                   16'($urandom_range(0, 6)), $urandom);
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
                if (pick == 1)
                    cut_message($urandom_range(1, msg_bytes.size()));
                else if (pick == 2)
                    msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
            end
            send_message();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        want_id = '0;
        clear_parser();
        test_answer_records();
        test_query_id();
        test_header_checks();
        test_name_rules();
        test_truncation();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();
        drain();
        if (mismatch_count == 0)
            $display("dns_a_response_parser_tb: clean");
        else
            $display("dns_a_response_parser_tb: errors");
        $finish;
    end

endmodule
